@@ sv/prfs_pkg.sv @@
// Package: shared types and constants for the piece range to file segment mapper.
`timescale 1ns / 1ps
package prfs_pkg;
  localparam int MaxFiles = 64;
  localparam int IdxW = $clog2(MaxFiles);
  localparam int FcW = 7;
  localparam int LenW = 48;
  localparam int PsW = 25;
  localparam int PcW = 21;
  localparam int PnW = 20;
  localparam int OffW = 24;
  localparam int CfgW = 48;
  localparam int QDepth = 2;

  localparam logic [1:0] CfgPieceSize = 2'd0;
  localparam logic [1:0] CfgPieceCount = 2'd1;
  localparam logic [1:0] CfgTotalSize = 2'd2;
  localparam logic [1:0] CfgFileCount = 2'd3;

  typedef enum logic [2:0] {
    StOk = 3'd0, StBadPiece = 3'd1, StTooLong = 3'd2,
    StBadOffset = 3'd3, StBeyond = 3'd4, StPastLast = 3'd5
  } status_t;

  typedef struct packed {
    logic [LenW-1:0] pos;
    logic [PsW-1:0] len;
    status_t status;
  } job_t;

  typedef enum logic [2:0] {
    FIdle, FMul, FLast, FCheck, FPush
  } fstate_t;

  typedef enum logic [1:0] {
    BIdle, BRead, BSeek, BEmit
  } bstate_t;
endpackage

@@ sv/prfs_ram.sv @@
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module prfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/prfs_front.sv @@
// Front end: checks a map request against piece geometry and forms a job.
`timescale 1ns / 1ps
module prfs_front import prfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic take,
  input  logic [PnW-1:0] piece_number,
  input  logic [OffW-1:0] offset_in_piece,
  input  logic [PsW-1:0] request_length,
  input  logic [PsW-1:0] piece_size,
  input  logic [PcW-1:0] piece_count,
  input  logic [LenW-1:0] total_size,
  input  logic q_full,
  output logic push,
  output job_t job,
  output logic busy
);
  fstate_t state_r, state_nxt;
  logic [PnW-1:0] pn_r;
  logic [OffW-1:0] off_r;
  logic [PsW-1:0] len_r;
  logic [LenW-1:0] base_r, lbase_r;
  logic [PsW-1:0] pbytes_r;
  logic [PsW-1:0] pbytes_nxt;
  logic [LenW-1:0] pos_w, rem_w;
  status_t st_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FIdle;
    end else begin
      state_r <= state_nxt;
    end
    if (take) begin
      pn_r <= piece_number;
      off_r <= offset_in_piece;
      len_r <= request_length;
    end
    if (state_r == FMul) begin
      base_r <= LenW'(pn_r * piece_size);
      lbase_r <= LenW'((piece_count - PcW'(1)) * piece_size);
    end
    if (state_r == FLast) begin
      pbytes_r <= pbytes_nxt;
    end
  end

  always_comb begin
    rem_w = total_size - lbase_r;
    pbytes_nxt = piece_size;
    if (PcW'(pn_r) + PcW'(1) == piece_count) begin
      if (total_size <= lbase_r) begin
        pbytes_nxt = '0;
      end else if (rem_w < LenW'(piece_size)) begin
        pbytes_nxt = PsW'(rem_w);
      end
    end
    pos_w = base_r + LenW'(off_r);
    priority if (PcW'(pn_r) >= piece_count) begin
      st_w = StBadPiece;
    end else if (len_r > pbytes_r) begin
      st_w = StTooLong;
    end else if (PsW'(off_r) >= pbytes_r) begin
      st_w = StBadOffset;
    end else if (pos_w >= total_size) begin
      st_w = StBeyond;
    end else begin
      st_w = StOk;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FCheck) begin
      job.pos <= pos_w;
      job.len <= len_r;
      job.status <= st_w;
    end
  end

  always_comb begin
    state_nxt = state_r;
    push = 1'b0;
    busy = (state_r != FIdle);
    unique case (state_r)
      FIdle: if (take) state_nxt = FMul;
      FMul: state_nxt = FLast;
      FLast: state_nxt = FCheck;
      FCheck: state_nxt = FPush;
      FPush: begin
        if (!q_full) begin
          push = 1'b1;
          state_nxt = FIdle;
        end
      end
      default: state_nxt = FIdle;
    endcase
  end
endmodule

@@ sv/prfs_queue.sv @@
// Small job queue between front and back end.
`timescale 1ns / 1ps
module prfs_queue import prfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);
  job_t slot_r [QDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) slot_r[wp_r] <= push_job;
  end
  assign head = slot_r[rp_r];
  assign full = (cnt_r == 2'(QDepth));
  assign empty = (cnt_r == '0);
endmodule

@@ sv/prfs_back.sv @@
// Back end: walks the file length table and emits segments.
`timescale 1ns / 1ps
module prfs_back import prfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  job_t q_head,
  output logic q_pop,
  input  logic [FcW-1:0] file_count,
  output logic [IdxW-1:0] rd_addr,
  input  logic [LenW-1:0] rd_data,
  output logic busy,
  output logic out_valid,
  output logic [IdxW-1:0] out_file_number,
  output logic [LenW-1:0] out_file_position,
  output logic [PsW-1:0] out_byte_count,
  output logic out_last,
  output logic [2:0] out_status
);
  bstate_t state_r, state_nxt;
  logic [IdxW:0] i_r, i_nxt;
  logic [LenW-1:0] pos_r, pos_nxt;
  logic [PsW-1:0] len_r, len_nxt;
  logic emit_r, emit_nxt;
  logic [IdxW:0] fc;
  logic [LenW-1:0] room, cnt48;
  logic [PsW-1:0] cnt;
  logic ov_nxt, ol_nxt;
  logic [IdxW-1:0] ofn_nxt;
  logic [LenW-1:0] opos_nxt;
  logic [PsW-1:0] ocnt_nxt;
  status_t ost_nxt;

  assign fc = (file_count > FcW'(MaxFiles)) ? (IdxW+1)'(MaxFiles) : (IdxW+1)'(file_count);
  assign rd_addr = i_r[IdxW-1:0];
  assign busy = (state_r != BIdle);
  assign room = rd_data - pos_r;
  assign cnt48 = (LenW'(len_r) < room) ? LenW'(len_r) : room;
  assign cnt = PsW'(cnt48);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BIdle;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= ov_nxt;
    end
    i_r <= i_nxt;
    pos_r <= pos_nxt;
    len_r <= len_nxt;
    emit_r <= emit_nxt;
    out_file_number <= ofn_nxt;
    out_file_position <= opos_nxt;
    out_byte_count <= ocnt_nxt;
    out_last <= ol_nxt;
    out_status <= ost_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    pos_nxt = pos_r;
    len_nxt = len_r;
    emit_nxt = emit_r;
    q_pop = 1'b0;
    ov_nxt = 1'b0;
    ol_nxt = 1'b1;
    ofn_nxt = '0;
    opos_nxt = '0;
    ocnt_nxt = '0;
    ost_nxt = StOk;
    unique case (state_r)
      BIdle: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          i_nxt = '0;
          pos_nxt = q_head.pos;
          len_nxt = q_head.len;
          emit_nxt = 1'b0;
          if (q_head.status != StOk) begin
            ov_nxt = 1'b1;
            ost_nxt = q_head.status;
          end else if (fc == '0) begin
            ov_nxt = 1'b1;
            ost_nxt = StPastLast;
          end else begin
            state_nxt = BRead;
          end
        end
      end
      BRead: state_nxt = emit_r ? BEmit : BSeek;
      BSeek: begin
        if (rd_data <= pos_r) begin
          pos_nxt = pos_r - rd_data;
          i_nxt = i_r + 1'b1;
          if (i_r + 1'b1 >= fc) begin
            ov_nxt = 1'b1;
            ost_nxt = StPastLast;
            state_nxt = BIdle;
          end else begin
            state_nxt = BRead;
          end
        end else if (len_r == '0) begin
          ov_nxt = 1'b1;
          ofn_nxt = i_r[IdxW-1:0];
          opos_nxt = pos_r;
          state_nxt = BIdle;
        end else begin
          state_nxt = BEmit;
        end
      end
      BEmit: begin
        ov_nxt = 1'b1;
        ofn_nxt = i_r[IdxW-1:0];
        opos_nxt = pos_r;
        ocnt_nxt = cnt;
        len_nxt = len_r - cnt;
        if (len_r == cnt) begin
          state_nxt = BIdle;
        end else if (i_r + 1'b1 >= fc) begin
          ost_nxt = StPastLast;
          state_nxt = BIdle;
        end else begin
          ol_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
          pos_nxt = '0;
          emit_nxt = 1'b1;
          state_nxt = BRead;
        end
      end
      default: state_nxt = BIdle;
    endcase
  end
endmodule

@@ sv/piece_range_to_file_segments.sv @@
// Top level of the piece range to file segment mapper.
// A load item (in_mode 0) writes one file length and gives no result.
// A map item passes through the front end and queue in steps (multiply, last piece bytes,
// checks, push, pop); a rejected request shows its result in the cycle after the pop.
// The back end then reads the RAM (BRead) and seeks (BSeek) for each file passed before
// the start, reads, seeks and emits (BEmit) for the first segment, and reads and emits
// for each further segment. busy stays high until the back end has loaded the
// final result into its output register; out_valid marks each segment for one cycle
// and cannot be stalled. Since busy blocks new input, at most one checked request
// sits between front and back end.
`timescale 1ns / 1ps
module piece_range_to_file_segments import prfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_mode,
  input  logic [IdxW-1:0] in_entry_index,
  input  logic [LenW-1:0] in_entry_length,
  input  logic [PnW-1:0] in_piece_number,
  input  logic [OffW-1:0] in_offset_in_piece,
  input  logic [PsW-1:0] in_request_length,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_wdata,
  output logic out_valid,
  output logic [IdxW-1:0] out_file_number,
  output logic [LenW-1:0] out_file_position,
  output logic [PsW-1:0] out_byte_count,
  output logic out_last,
  output logic [2:0] out_status
);
  logic [PsW-1:0] piece_size_r;
  logic [PcW-1:0] piece_count_r;
  logic [LenW-1:0] total_size_r;
  logic [FcW-1:0] file_count_r;
  logic accept, f_busy, b_busy, push, pop, q_full, q_empty;
  job_t push_job, head;
  logic [IdxW-1:0] rd_addr;
  logic [LenW-1:0] rd_data;

  assign accept = start && !busy;
  assign busy = f_busy || b_busy || !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piece_size_r <= PsW'(262144);
      piece_count_r <= PcW'(1);
      total_size_r <= '0;
      file_count_r <= FcW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgPieceSize: piece_size_r <= cfg_wdata[PsW-1:0];
        CfgPieceCount: piece_count_r <= cfg_wdata[PcW-1:0];
        CfgTotalSize: total_size_r <= cfg_wdata[LenW-1:0];
        CfgFileCount: file_count_r <= cfg_wdata[FcW-1:0];
        default: ;
      endcase
    end
  end

  prfs_ram #(.Width(LenW), .Depth(MaxFiles)) u_ram (
    .clk(clk), .we(accept && !in_mode), .waddr(in_entry_index),
    .wdata(in_entry_length), .raddr(rd_addr), .rdata(rd_data)
  );

  prfs_front u_front (
    .clk(clk), .rst_n(rst_n), .take(accept && in_mode),
    .piece_number(in_piece_number), .offset_in_piece(in_offset_in_piece),
    .request_length(in_request_length), .piece_size(piece_size_r),
    .piece_count(piece_count_r), .total_size(total_size_r),
    .q_full(q_full), .push(push), .job(push_job), .busy(f_busy)
  );

  prfs_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
    .head(head), .full(q_full), .empty(q_empty)
  );

  prfs_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(head), .q_pop(pop),
    .file_count(file_count_r), .rd_addr(rd_addr), .rd_data(rd_data),
    .busy(b_busy), .out_valid(out_valid), .out_file_number(out_file_number),
    .out_file_position(out_file_position), .out_byte_count(out_byte_count),
    .out_last(out_last), .out_status(out_status)
  );
endmodule

@@ dv/piece_range_to_file_segments_tb.sv @@
// Testbench for the piece range to file segment mapper: directed and random maps checked
// against an in-bench predictor.
`timescale 1ns / 1ps
module piece_range_to_file_segments_tb;
  import prfs_pkg::*;

  localparam int Limit = 800000;
  localparam int Settle = 160;

  typedef struct {
    logic mode;
    logic [IdxW-1:0] slot;
    logic [LenW-1:0] flen;
    logic [PnW-1:0] piece;
    logic [OffW-1:0] off;
    logic [PsW-1:0] rlen;
  } req_t;

  typedef struct {
    logic [IdxW-1:0] fnum;
    logic [LenW-1:0] fpos;
    logic [PsW-1:0] cnt;
    logic last;
    status_t st;
  } seg_t;

  logic clk, rst_n, start, busy;
  logic in_mode;
  logic [IdxW-1:0] in_entry_index;
  logic [LenW-1:0] in_entry_length;
  logic [PnW-1:0] in_piece_number;
  logic [OffW-1:0] in_offset_in_piece;
  logic [PsW-1:0] in_request_length;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CfgW-1:0] cfg_wdata;
  logic out_valid;
  logic [IdxW-1:0] out_file_number;
  logic [LenW-1:0] out_file_position;
  logic [PsW-1:0] out_byte_count;
  logic out_last;
  logic [2:0] out_status;

  piece_range_to_file_segments dut (.*);

  // predictor state
  logic [63:0] m_psize, m_pcount, m_total, m_fcount;
  logic [63:0] m_len [MaxFiles];

  seg_t segs_due [$];
  int errors = 0;
  int cycles = 0;
  int maps_sent = 0;
  int loads_sent = 0;
  int segs_seen = 0;
  bit idle_on = 1;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    seg_t e;
    if (rst_n && out_valid) begin
      segs_seen++;
      if (segs_due.size() == 0) begin
        report($sformatf("unexpected segment file %0d", out_file_number));
      end else begin
        e = segs_due.pop_front();
        if (out_file_number !== e.fnum)
          report($sformatf("file_number %0d want %0d", out_file_number, e.fnum));
        if (out_file_position !== e.fpos)
          report($sformatf("file_position %0d want %0d", out_file_position, e.fpos));
        if (out_byte_count !== e.cnt)
          report($sformatf("byte_count %0d want %0d", out_byte_count, e.cnt));
        if (out_last !== e.last)
          report($sformatf("last %0b want %0b", out_last, e.last));
        if (out_status !== e.st)
          report($sformatf("status %0d want %0d", out_status, e.st));
      end
    end
  end

  function automatic logic [63:0] piece_bytes(input logic [63:0] p);
    logic [63:0] base, rem;
    if (m_pcount == 0 || p + 1 != m_pcount) return m_psize;
    base = (m_pcount - 1) * m_psize;
    if (m_total <= base) return 0;
    rem = m_total - base;
    return rem > m_psize ? m_psize : rem;
  endfunction

  function automatic void push_seg(input logic [63:0] f, input logic [63:0] p,
                                   input logic [63:0] c, input logic l, input status_t s);
    seg_t e;
    e.fnum = f[IdxW-1:0];
    e.fpos = p[LenW-1:0];
    e.cnt = c[PsW-1:0];
    e.last = l;
    e.st = s;
    segs_due.push_back(e);
  endfunction

  function automatic void map_range(input req_t r);
    logic [63:0] pb, pos, fc, i, rlen, room, cnt;
    if (r.mode == 1'b0) begin
      m_len[r.slot] = r.flen;
      return;
    end
    rlen = r.rlen;
    if (r.piece >= m_pcount) begin push_seg(0, 0, 0, 1, StBadPiece); return; end
    pb = piece_bytes(r.piece);
    if (rlen > pb) begin push_seg(0, 0, 0, 1, StTooLong); return; end
    if (r.off >= pb) begin push_seg(0, 0, 0, 1, StBadOffset); return; end
    pos = r.piece * m_psize + r.off;
    if (pos >= m_total) begin push_seg(0, 0, 0, 1, StBeyond); return; end
    fc = m_fcount > MaxFiles ? MaxFiles : m_fcount;
    i = 0;
    while (i < fc && m_len[i] <= pos) begin
      pos -= m_len[i];
      i++;
    end
    if (i >= fc) begin push_seg(0, 0, 0, 1, StPastLast); return; end
    if (rlen == 0) begin push_seg(i, pos, 0, 1, StOk); return; end
    while (rlen != 0) begin
      room = m_len[i] - pos;
      cnt = rlen < room ? rlen : room;
      rlen -= cnt;
      if (rlen == 0) begin push_seg(i, pos, cnt, 1, StOk); return; end
      if (i + 1 >= fc) begin push_seg(i, pos, cnt, 1, StPastLast); return; end
      push_seg(i, pos, cnt, 0, StOk);
      i++;
      pos = 0;
    end
  endfunction

  task automatic send_item(input req_t r);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= r.mode;
    in_entry_index <= r.slot;
    in_entry_length <= r.flen;
    in_piece_number <= r.piece;
    in_offset_in_piece <= r.off;
    in_request_length <= r.rlen;
    do @(posedge clk); while (busy);
    map_range(r);
    if (r.mode) maps_sent++;
    else loads_sent++;
  endtask

  task automatic send_load(input int slot, input logic [63:0] flen);
    req_t r;
    r = '{mode: 1'b0, slot: slot, flen: flen, piece: $urandom, off: $urandom,
          rlen: $urandom};
    send_item(r);
  endtask

  task automatic send_map(input logic [63:0] p, input logic [63:0] o, input logic [63:0] l);
    req_t r;
    r = '{mode: 1'b1, slot: $urandom, flen: {$urandom, $urandom}, piece: p, off: o,
          rlen: l};
    send_item(r);
  endtask

  // hold the sender until the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (segs_due.size() != 0 || busy) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgPieceSize: m_psize = val[PsW-1:0];
      CfgPieceCount: m_pcount = val[PcW-1:0];
      CfgTotalSize: m_total = val[LenW-1:0];
      CfgFileCount: m_fcount = val[FcW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [63:0] ps, input logic [63:0] pc,
                              input logic [63:0] tot, input logic [63:0] fc);
    drain();
    cfg_write(CfgPieceSize, ps);
    cfg_write(CfgPieceCount, pc);
    cfg_write(CfgTotalSize, tot);
    cfg_write(CfgFileCount, fc);
  endtask

  task automatic test_reset_defaults();
    for (int s = 0; s < MaxFiles; s++) send_load(s, $urandom_range(0, 20));
    send_map(0, 0, 0);
    send_map(1, 0, 0);
  endtask

  task automatic test_directed();
    set_geometry(8, 3, 20, 5);
    send_load(0, 5);
    send_load(1, 0);
    send_load(2, 0);
    send_load(3, 12);
    send_load(4, 3);
    send_map(0, 0, 8);
    send_map(0, 3, 0);
    send_map(0, 0, 9);
    send_map(0, 8, 1);
    send_map(3, 0, 1);
    send_map(2, 3, 1);
    send_map(2, 0, 4);
    set_geometry(8, 4, 30, 5);
    send_map(2, 0, 8);
    send_map(2, 4, 8);
    set_geometry(8, 4, 20, 5);
    send_map(2, 4, 1);
    set_geometry(8, 4, 20, 0);
    send_map(0, 0, 4);
    set_geometry(1, 2000, 1000, 127);
    send_map(3, 0, 1);
    send_map(1999, 0, 1);
    drain();
    send_load(0, 48'hFFFF_FFFF_FFFF);
    set_geometry(25'h100_0000, 21'h10_0000, 48'hFFFF_FFFF_FFFF, 1);
    send_map(20'hF_FFFF, 24'hFF_FFFF, 1);
    send_map(20'h7_FFFF, 0, 25'h100_0000);
    send_map(20'hF_FFFF, 24'h80_0000, 25'h100_0000);
  endtask

  task automatic random_phase(input int n_items);
    int fc;
    logic [63:0] sum, ps, pc, tot, pb, p;
    fc = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    drain();
    sum = 0;
    for (int s = 0; s < fc; s++) begin
      p = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
      send_load(s, p);
      sum += p;
    end
    tot = sum;
    case ($urandom_range(0, 5))
      0: tot = sum + $urandom_range(1, 10);
      1: tot = sum > 3 ? sum - $urandom_range(1, 3) : sum;
      default: ;
    endcase
    ps = $urandom_range(1, 32);
    pc = (tot + ps - 1) / ps;
    if (pc == 0) pc = 1;
    pc += $urandom_range(0, 3) == 0;
    set_geometry(ps, pc, tot, fc);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 3) == 0) send_load($urandom_range(0, 63), {$urandom, $urandom});
        else send_load($urandom_range(0, 63), $urandom_range(0, 20));
        continue;
      end
      if ($urandom_range(0, 19) == 0) drain();
      p = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, pc - 1);
      pb = piece_bytes(p);
      send_map(p,
               ($urandom_range(0, 6) == 0 || pb == 0) ? $urandom : $urandom_range(0, pb - 1),
               ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, pb));
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) random_phase(28);
  endtask

  task automatic test_back_to_back();
    idle_on = 0;
    random_phase(30);
    idle_on = 1;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = 1'b0;
    in_entry_index = '0;
    in_entry_length = '0;
    in_piece_number = '0;
    in_offset_in_piece = '0;
    in_request_length = '0;
    cfg_we = 1'b0;
    cfg_index = CfgPieceSize;
    cfg_wdata = '0;
    m_psize = 262144;
    m_pcount = 1;
    m_total = 0;
    m_fcount = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random();
    test_back_to_back();
    drain();
    $display("Covered %0d map requests and %0d table loads, %0d segments checked,",
             maps_sent, loads_sent, segs_seen);
    $display("over directed geometry extremes and random layouts with idle gaps.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ piece_range_to_file_segments.f @@
sv/prfs_pkg.sv
sv/prfs_ram.sv
sv/prfs_front.sv
sv/prfs_queue.sv
sv/prfs_back.sv
sv/piece_range_to_file_segments.sv
dv/piece_range_to_file_segments_tb.sv
